// ===== rtl/vdn_pkg.sv =====
// Shared types and constants for the vector difference norm block.
// No dependencies; used by every module under rtl.
package vdn_pkg;

    localparam int SUM_WIDTH   = 64;
    localparam int NORM_WIDTH  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ROOT_STEPS  = NORM_WIDTH;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int REM_W       = NORM_WIDTH + 2;

    // One finished vector, handed from the accumulator to the back end.
    typedef struct packed {
        logic                  use_max;
        logic [SUM_WIDTH-1:0]  sum;
        logic [NORM_WIDTH-1:0] largest;
        logic                  ovf;
    } vdn_entry_t;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic [QCNT_W-1:0] level;
        logic              nonempty;
    } vdn_qstat_t;

endpackage

// ===== rtl/vector_difference_norm.sv =====
// Top level of the vector difference norm block: L2 or max-norm of a - b.
// Depends on vdn_pkg, vdn_front, vdn_queue and vdn_root.
//
//   channel   | direction | handshake          | beat carries
//   ----------+-----------+--------------------+----------------------------------
//   elements  | in        | push / full        | element_a, element_b, last_element
//   result    | out       | pop / empty        | norm_value, saturated
//   config    | in        | cfg_write          | cfg_data (use_max_norm)
//
// The front end takes one element pair per cycle while full is low and accumulates
// it after the input and squaring stages. A marked pair closes a vector; in
// Euclidean mode the bit-serial square root (two radicand bits per cycle) sets
// the pace of its result.
// Up to four closed vectors wait in the queue; full rises while they fill it.
// Reset is asynchronous and active low; no clearing pass is needed after it.
module vector_difference_norm
    import vdn_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [ELEMENT_WIDTH-1:0] element_a,
    input  logic signed [ELEMENT_WIDTH-1:0] element_b,
    input  logic                            last_element,
    output logic                            empty,
    input  logic                            pop,
    output logic [NORM_WIDTH-1:0]           norm_value,
    output logic                            saturated,
    input  logic                            cfg_write,
    input  logic                            cfg_data
);

    // Closed vectors travel from the accumulator to the root unit as queue entries.
    logic       q_push;
    logic       q_pop;
    vdn_entry_t q_entry;
    vdn_entry_t q_head;
    vdn_qstat_t q_stat;

    vdn_front #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .element_a    (element_a),
        .element_b    (element_b),
        .last_element (last_element),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    vdn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    vdn_root u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .norm_value (norm_value),
        .saturated  (saturated)
    );

    // The full flag must keep the queue from ever being written past its depth.
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.level < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while at capacity");

    // A marked beat reaches the queue exactly after the two pipeline stages.
    a_last_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && last_element) |=> ##1 q_push)
        else $error("closed vector did not reach the queue on time");

    // A queue holding its full depth must hold off the input side.
    a_full_when_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.level == QCNT_W'(QUEUE_DEPTH)) |-> full)
        else $error("input accepted while the queue is at capacity");

endmodule

// ===== rtl/vdn_front.sv =====
// Front end: input stage, squaring stage and the saturating accumulators.
// Depends on vdn_pkg; pushes one entry per finished vector into vdn_queue.
module vdn_front
    import vdn_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [ELEMENT_WIDTH-1:0] element_a,
    input  logic signed [ELEMENT_WIDTH-1:0] element_b,
    input  logic                            last_element,
    input  logic                            cfg_write,
    input  logic                            cfg_data,
    input  vdn_qstat_t                      q_stat,
    output logic                            q_push,
    output vdn_entry_t                      q_entry
);

    localparam int W     = ELEMENT_WIDTH;
    localparam int CAP_W = W - 1;
    localparam int SQ_W  = 2 * W;

    logic              mode_reg;
    logic              s1_valid_reg, s2_valid_reg;
    logic              s1_last_reg, s2_last_reg;
    logic [W-1:0]      s1_mag_reg;
    logic [CAP_W-1:0]  s1_cap_reg, s2_cap_reg;
    logic              s1_ovf_reg, s2_ovf_reg;
    logic [SQ_W-1:0]   s2_sq_reg;
    logic [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic [CAP_W-1:0]  max_reg, max_next;
    logic              ovf_reg, ovf_next;

    logic              accept;
    logic signed [W:0] diff;
    logic [W:0]        diff_abs;
    logic [W-1:0]      mag;
    logic [SUM_WIDTH:0] sum_wide;
    logic [SUM_WIDTH-1:0] sum_fin;
    logic [CAP_W-1:0]  max_fin;
    logic              ovf_fin;
    logic [QCNT_W:0]   committed;

    // Entries already claimed: queue level plus marked items still in the pipe.
    assign committed = {1'b0, q_stat.level}
                     + (QCNT_W+1)'(s1_valid_reg & s1_last_reg)
                     + (QCNT_W+1)'(s2_valid_reg & s2_last_reg);
    assign full   = committed >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept = push & ~full;

    assign diff     = {element_a[W-1], element_a} - {element_b[W-1], element_b};
    assign diff_abs = diff[W] ? (~diff + 1'b1) : diff;
    assign mag      = diff_abs[W-1:0];

    assign sum_wide = {1'b0, sum_reg} + {1'b0, {(SUM_WIDTH-SQ_W){1'b0}}, s2_sq_reg};
    assign sum_fin  = sum_wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];
    assign max_fin  = (s2_cap_reg > max_reg) ? s2_cap_reg : max_reg;
    assign ovf_fin  = ovf_reg | s2_ovf_reg | sum_wide[SUM_WIDTH];

    assign q_push          = s2_valid_reg & s2_last_reg;
    assign q_entry.use_max = mode_reg;
    assign q_entry.sum     = sum_fin;
    assign q_entry.largest = {{(NORM_WIDTH-CAP_W){1'b0}}, max_fin};
    assign q_entry.ovf     = ovf_fin;

    always_comb
    begin
        sum_next = sum_reg;
        max_next = max_reg;
        ovf_next = ovf_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                sum_next = '0;
                max_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_fin;
                max_next = max_fin;
                ovf_next = ovf_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            max_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            sum_reg      <= sum_next;
            max_reg      <= max_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Payload stages need no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        s1_last_reg <= last_element;
        s1_mag_reg  <= mag;
        s1_cap_reg  <= mag[W-1] ? {CAP_W{1'b1}} : mag[CAP_W-1:0];
        s1_ovf_reg  <= mag[W-1];
        s2_last_reg <= s1_last_reg;
        s2_cap_reg  <= s1_cap_reg;
        s2_ovf_reg  <= s1_ovf_reg;
        s2_sq_reg   <= s1_mag_reg * s1_mag_reg;
    end

endmodule

// ===== rtl/vdn_queue.sv =====
// Short queue of finished vectors between the accumulator and the root unit.
// Depends on vdn_pkg for the entry type and the depth.
module vdn_queue
    import vdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_push,
    input  vdn_entry_t q_entry,
    input  logic       q_pop,
    output vdn_entry_t q_head,
    output vdn_qstat_t q_stat
);

    vdn_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_head          = slot_reg[rd_ptr_reg];
    assign q_stat.level    = count_reg;
    assign q_stat.nonempty = count_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(q_push) - QCNT_W'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            slot_reg[wr_ptr_reg] <= q_entry;
        end
    end

endmodule

// ===== rtl/vdn_root.sv =====
// Back end: bit-serial integer square root (bypassed in max-norm mode) and the result register.
// Depends on vdn_pkg; takes entries from vdn_queue.
module vdn_root
    import vdn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vdn_entry_t            q_head,
    input  vdn_qstat_t            q_stat,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [NORM_WIDTH-1:0] norm_value,
    output logic                  saturated
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SUM_WIDTH-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [NORM_WIDTH-1:0] root_reg, root_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NORM_WIDTH-1:0] out_norm_reg, out_norm_next;
    logic                  out_sat_reg, out_sat_next;

    logic [REM_W+1:0]      rem_shift, trial, rem_diff;
    logic                  fits;
    logic                  out_taken;

    assign out_taken = pop & out_valid_reg;
    assign empty      = ~out_valid_reg;
    assign norm_value = out_norm_reg;
    assign saturated  = out_sat_reg;

    // Two radicand bits per step; the trial subtrahend is 4*root + 1.
    assign rem_shift = {rem_reg, rad_reg[SUM_WIDTH-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign fits      = rem_shift >= trial;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~out_taken;
        out_norm_next  = out_norm_reg;
        out_sat_next   = out_sat_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.nonempty)
                begin
                    q_pop    = 1'b1;
                    ovf_next = q_head.ovf;
                    rad_next = q_head.sum;
                    rem_next = '0;
                    step_next = '0;
                    if (q_head.use_max)
                    begin
                        root_next  = q_head.largest;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        root_next  = '0;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                rem_next  = fits ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
                root_next = {root_reg[NORM_WIDTH-2:0], fits};
                rad_next  = {rad_reg[SUM_WIDTH-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_norm_next  = root_reg;
                    out_sat_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        ovf_reg      <= ovf_next;
        out_norm_reg <= out_norm_next;
        out_sat_reg  <= out_sat_next;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for vector_difference_norm: streams element pairs,
// predicts each vector's norm and saturation flag, and checks every result beat.
// Depends on vdn_pkg and on the vector_difference_norm RTL.
module testbench
    import vdn_pkg::*;
;

    localparam int EW        = 24;
    localparam int PEAK_POS  = 2 ** (EW - 1) - 1;
    localparam int PEAK_NEG  = -(2 ** (EW - 1));
    // Generous bound on cycles without any beat; the slowest legitimate gap is the
    // long receiver hold-off plus one square root.
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES = 400;

    // One element pair as offered on the input side.
    typedef struct {
        logic signed [EW-1:0] a;
        logic signed [EW-1:0] b;
        logic                 last;
    } element_pair_t;

    // One result beat: the norm and whether anything saturated in its vector.
    typedef struct {
        logic [NORM_WIDTH-1:0] value;
        logic                  sat;
    } norm_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic signed [EW-1:0]  element_a = '0;
    logic signed [EW-1:0]  element_b = '0;
    logic                  last_element = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [NORM_WIDTH-1:0] norm_value;
    logic                  saturated;
    logic                  cfg_write = 1'b0;
    logic                  cfg_data = 1'b0;

    // Pairs waiting to be driven, and norms waiting to be popped.
    element_pair_t pending_pairs[$];
    norm_beat_t    expected_norms[$];

    // Our own copy of the block's accumulators and of its mode register.
    logic [SUM_WIDTH-1:0] acc_sum = '0;
    logic [EW-1:0]        peak_diff = '0;
    logic                 sat_seen = 1'b0;
    logic                 norm_mode = 1'b0;

    // Idling percentages, set per phase by the sequencer.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The sequencer asks for a long receiver hold-off by bumping hold_asked;
    // the result monitor notices and counts the hold-off down on its own.
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;

    int errors = 0;
    int quiet_cycles = 0;

    vector_difference_norm #(
        .ELEMENT_WIDTH(EW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .element_a(element_a),
        .element_b(element_b),
        .last_element(last_element),
        .empty(empty),
        .pop(pop),
        .norm_value(norm_value),
        .saturated(saturated),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Bit-at-a-time integer square root: keep each root bit whose square still fits.
    function automatic logic [NORM_WIDTH-1:0] floor_root(input logic [SUM_WIDTH-1:0] x);
        logic [NORM_WIDTH-1:0] root;
        logic [NORM_WIDTH-1:0] trial;
        logic [SUM_WIDTH-1:0]  trial_sq;
        root = '0;
        for (int i = NORM_WIDTH - 1; i >= 0; i--)
        begin
            trial = root | (NORM_WIDTH'(1) << i);
            trial_sq = SUM_WIDTH'(trial) * SUM_WIDTH'(trial);
            if (trial_sq <= x)
                root = trial;
        end
        return root;
    endfunction

    // Fold one accepted pair into the accumulators. A marked pair closes the vector:
    // the norm is chosen by the mode at that moment, queued, and the state cleared.
    function automatic void absorb_pair(input element_pair_t p);
        logic signed [EW:0]   diff;
        logic [EW:0]          mag;
        logic [2*EW+1:0]      square;
        logic [EW-1:0]        capped;
        logic [SUM_WIDTH:0]   wide_sum;
        norm_beat_t           beat;
        diff = p.a - p.b;
        mag = diff[EW] ? -diff : diff;
        square = mag * mag;
        // The maximum saturates at the largest positive element; the square does not.
        if (mag > PEAK_POS)
        begin
            capped = EW'(PEAK_POS);
            sat_seen = 1'b1;
        end
        else
        begin
            capped = mag[EW-1:0];
        end
        if (capped > peak_diff)
            peak_diff = capped;
        wide_sum = {1'b0, acc_sum} + square;
        if (wide_sum[SUM_WIDTH])
        begin
            acc_sum = '1;
            sat_seen = 1'b1;
        end
        else
        begin
            acc_sum = wide_sum[SUM_WIDTH-1:0];
        end
        if (p.last)
        begin
            beat.value = norm_mode ? NORM_WIDTH'(peak_diff) : floor_root(acc_sum);
            beat.sat = sat_seen;
            expected_norms.insert(expected_norms.size(), beat);
            acc_sum = '0;
            peak_diff = '0;
            sat_seen = 1'b0;
        end
    endfunction

    // Input driver. A beat counts at an edge where push is high and full is low;
    // an offered pair that meets full stays on the ports until it gets in.
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            absorb_pair(pending_pairs.pop_front());
        end
        if (push && full)
        begin
            // Hold the current offer.
        end
        else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            element_a <= pending_pairs[0].a;
            element_b <= pending_pairs[0].b;
            last_element <= pending_pairs[0].last;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // Result monitor. Each popped beat is checked field by field against the oldest
    // prediction; pop itself is thrown at random, or held low during a hold-off.
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_norms.size() == 0)
            begin
                $display("%0t: unexpected result beat, norm_value %0d saturated %0b",
                         $time, norm_value, saturated);
                errors++;
            end
            else
            begin
                if (norm_value !== expected_norms[0].value)
                begin
                    $display("%0t: norm_value expected %0d, got %0d",
                             $time, expected_norms[0].value, norm_value);
                    errors++;
                end
                if (saturated !== expected_norms[0].sat)
                begin
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, expected_norms[0].sat, saturated);
                    errors++;
                end
                void'(expected_norms.pop_front());
            end
        end
        if (hold_asked != hold_given)
        begin
            hold_given = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: the run is stuck if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_pair(input int a, input int b, input logic last);
        element_pair_t p;
        p.a = EW'(a);
        p.b = EW'(b);
        p.last = last;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // Mostly full-range values, with a share of small ones so that many vectors
    // stay clear of saturation, and a share of the two extremes.
    function automatic int pick_element();
        case ($urandom_range(7))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2, 3: return int'($urandom_range(8192)) - 4096;
            default: return int'($signed(EW'($urandom)));
        endcase
    endfunction

    task automatic queue_vector(input int len);
        for (int i = 0; i < len; i++)
            add_pair(pick_element(), pick_element(), i == len - 1);
    endtask

    // Edge cases of the difference: zero, both extreme differences, the exact
    // saturation boundary and one past it, and saturation inside a longer vector.
    task automatic queue_edge_cases();
        add_pair(0, 0, 1'b1);
        add_pair(PEAK_POS, PEAK_NEG, 1'b1);
        add_pair(PEAK_NEG, PEAK_POS, 1'b1);
        add_pair(PEAK_POS, PEAK_POS, 1'b1);
        add_pair(PEAK_NEG, PEAK_NEG, 1'b1);
        add_pair(PEAK_POS, 0, 1'b1);
        add_pair(PEAK_NEG, 0, 1'b1);
        add_pair(0, 1, 1'b1);
        add_pair(4096, 0, 1'b0);
        add_pair(0, 4096, 1'b0);
        add_pair(-4096, 4096, 1'b1);
        add_pair(-1, 0, 1'b0);
        add_pair(PEAK_POS, PEAK_NEG, 1'b0);
        add_pair(0, 0, 1'b1);
    endtask

    // Wait until the driver has handed over every pending pair.
    task automatic wait_sent();
        while (pending_pairs.size() != 0 || push)
            @(negedge clk);
    endtask

    // Wait until every predicted result has been popped and the block has settled.
    task automatic wait_drained();
        wait_sent();
        while (expected_norms.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_write <= 1'b0;
        norm_mode = mode;
        @(negedge clk);
    endtask

    // One idling phase: chunks of random vectors, each chunk in a random mode.
    task automatic run_phase(input int send_pct, input int recv_pct, input int pairs);
        int done;
        int chunk;
        int len;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        done = 0;
        while (done < pairs)
        begin
            wait_drained();
            write_mode(1'($urandom_range(1)));
            chunk = 0;
            while (chunk < 90)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(32, 8) : $urandom_range(6, 1);
                queue_vector(len);
                chunk += len;
            end
            done += chunk;
        end
    endtask

    // Sequencer: reset, directed cases in both modes, a mode change inside a
    // vector, back-pressure, and random phases.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset leaves the block in Euclidean mode.
        queue_edge_cases();
        wait_drained();
        write_mode(1'b1);
        queue_edge_cases();
        wait_drained();

        // The mode is taken when the marked pair arrives, not when the vector starts.
        write_mode(1'b0);
        add_pair(PEAK_POS, 0, 1'b0);
        add_pair(-300, 700, 1'b0);
        add_pair(12345, -54321, 1'b0);
        wait_drained();
        write_mode(1'b1);
        add_pair(8, -8, 1'b1);
        wait_drained();
        add_pair(PEAK_NEG, 5, 1'b0);
        add_pair(100, 99, 1'b0);
        wait_drained();
        write_mode(1'b0);
        add_pair(7, 3, 1'b1);
        wait_drained();

        // Receiver holds off while one-pair vectors keep coming, so the result
        // queue fills and full must stall the input; then the sender waits for all.
        write_mode(1'b1);
        hold_asked = hold_asked + 1;
        for (int i = 0; i < 40; i++)
            queue_vector(1);
        wait_drained();
        write_mode(1'b0);
        hold_asked = hold_asked + 1;
        for (int i = 0; i < 12; i++)
            queue_vector(1);
        wait_drained();

        run_phase(0, 0, 360);
        run_phase(72, 0, 360);
        run_phase(0, 72, 360);
        run_phase(32, 32, 360);
        wait_drained();

        if (expected_norms.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_norms.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
